// ----- rtl/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, command codes and controller/datapath interface structs for
// the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  typedef struct packed {
    logic        [CMD_W-1:0] cmd;
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] elem_value;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic        [POS_W-1:0] found_position;
    logic        [POS_W-1:0] list_length;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic cap;
    logic shift;
    logic up;
    logic cmp;
    logic ptr_inc;
    logic ptr_dec;
    logic wr_val;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_ok;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             pos_ok;
    logic             ins_ok;
    logic             ins_tail;
    logic             cnt_zero;
    logic             ptr_first;
    logic             ptr_end;
    logic             hit;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/pal_ram.sv -----
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pal_dp.sv -----
// ----------------------------------------------------------------------------
// pal_dp
// Datapath: latched item, entry pointer, length, entry RAM with a one-deep
// pending stage for shift writes, captures and compares, result and output
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_dp #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pal_pkg::req_t      req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output pal_pkg::rsp_t           rsp,
  input  wire pal_pkg::dp_cmd_t   cmd,
  output pal_pkg::dp_stat_t       stat
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [pal_pkg::CMD_W-1:0]        op;
  logic [pal_pkg::POS_W-1:0]        pos;
  logic signed [pal_pkg::VAL_W-1:0] val;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    ptr;
  logic                             pend_shift;
  logic                             pend_cap;
  logic                             pend_cmp;
  logic                             pend_up;
  logic [CW-1:0]                    pend_idx;
  logic                             res_ok;
  logic signed [pal_pkg::VAL_W-1:0] res_rd;
  logic [pal_pkg::POS_W-1:0]        res_fpos;

  logic                             wr_en;
  logic [IW-1:0]                    wr_addr;
  logic [pal_pkg::VAL_W-1:0]        wr_data;
  logic [pal_pkg::VAL_W-1:0]        rdata;
  logic [IW-1:0]                    pos_idx;
  logic                             hit;

  assign pos_idx = IW'(32'(pos) - 32'd1);
  assign hit     = pend_cmp && (rdata == val);

  // shift writes land in the cycle after their read; the value write never overlaps
  always_comb begin
    wr_en   = pend_shift || cmd.wr_val;
    wr_addr = pos_idx;
    wr_data = val;
    if (pend_shift) begin
      wr_addr = pend_up ? IW'(32'(pend_idx) + 32'd1) : IW'(32'(pend_idx) - 32'd1);
      wr_data = rdata;
    end
  end

  pal_ram #(
    .WIDTH (pal_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (ptr[IW-1:0]),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rsp_valid  <= 1'b0;
      pend_shift <= 1'b0;
      pend_cap   <= 1'b0;
      pend_cmp   <= 1'b0;
    end else begin
      pend_shift <= cmd.rd && cmd.shift;
      pend_cap   <= cmd.rd && cmd.cap;
      pend_cmp   <= cmd.rd && cmd.cmp;
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pend_up  <= cmd.up;
      pend_idx <= ptr;
    end
    if (cmd.load) begin
      op       <= req.cmd;
      pos      <= req.position;
      val      <= req.elem_value;
      res_ok   <= 1'b0;
      res_rd   <= '0;
      res_fpos <= '0;
      if (req.cmd == pal_pkg::CMD_INSERT) begin
        ptr <= count - CW'(1);
      end else if (req.cmd == pal_pkg::CMD_LOCATE) begin
        ptr <= '0;
      end else begin
        ptr <= CW'(32'(req.position) - 32'd1);
      end
    end else begin
      if (cmd.ptr_inc) begin
        ptr <= ptr + CW'(1);
      end else if (cmd.ptr_dec) begin
        ptr <= ptr - CW'(1);
      end
      if (cmd.set_ok || hit) begin
        res_ok <= 1'b1;
      end
      if (pend_cap) begin
        res_rd <= rdata;
      end
      if (hit) begin
        res_fpos <= pal_pkg::POS_W'(32'(pend_idx) + 32'd1);
      end
    end
    if (cmd.out_load) begin
      rsp.ok             <= res_ok;
      rsp.read_value     <= res_rd;
      rsp.found_position <= res_fpos;
      rsp.list_length    <= pal_pkg::POS_W'(count);
    end
  end

  always_comb begin
    stat.op        = op;
    stat.pos_ok    = (pos != '0) && (32'(pos) <= 32'(count));
    stat.ins_ok    = (pos != '0) && (32'(pos) <= 32'(count) + 32'd1)
                     && (32'(count) < 32'(CAPACITY));
    stat.ins_tail  = 32'(pos) == 32'(count) + 32'd1;
    stat.cnt_zero  = count == '0;
    stat.ptr_first = 32'(ptr) == 32'(pos) - 32'd1;
    stat.ptr_end   = ptr == count;
    stat.hit       = hit;
    stat.out_free  = !rsp_valid || !rsp_stall;
  end

  a_one_write_port: assert property (@(posedge clk) disable iff (rst)
    !(pend_shift && cmd.wr_val))
    else $error("value write collides with shift write");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(CAPACITY))
    else $error("length exceeds capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!cmd.cnt_inc && !cmd.cnt_dec && !cmd.cnt_clr) |=> $stable(count))
    else $error("length changed without a command");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while held");

endmodule

`default_nettype wire

// ----- rtl/pal_ctrl.sv -----
// ----------------------------------------------------------------------------
// pal_ctrl
// Controller: sequences each command, walking the entry RAM for insert, delete
// and locate, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  output pal_pkg::dp_cmd_t       cmd,
  input  wire pal_pkg::dp_stat_t stat
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_INS_WALK  = 4'd2;
  localparam logic [3:0] S_INS_DRAIN = 4'd3;
  localparam logic [3:0] S_INS_WR    = 4'd4;
  localparam logic [3:0] S_DEL_WALK  = 4'd5;
  localparam logic [3:0] S_DEL_FIN   = 4'd6;
  localparam logic [3:0] S_GET_FIN   = 4'd7;
  localparam logic [3:0] S_LOC_WALK  = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_DONE;
        unique case (stat.op)
          pal_pkg::CMD_INSERT: begin
            if (stat.ins_ok) begin
              state_next = stat.ins_tail ? S_INS_WR : S_INS_WALK;
            end
          end
          pal_pkg::CMD_DELETE: begin
            if (stat.pos_ok) begin
              cmd.rd      = 1'b1;
              cmd.cap     = 1'b1;
              cmd.ptr_inc = 1'b1;
              state_next  = S_DEL_WALK;
            end
          end
          pal_pkg::CMD_GET: begin
            if (stat.pos_ok) begin
              cmd.rd     = 1'b1;
              cmd.cap    = 1'b1;
              state_next = S_GET_FIN;
            end
          end
          pal_pkg::CMD_LOCATE: begin
            if (!stat.cnt_zero) begin
              state_next = S_LOC_WALK;
            end
          end
          pal_pkg::CMD_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.set_ok  = 1'b1;
          end
          default: begin
          end
        endcase
      end
      // move entries up one slot, from the tail down to the insert point
      S_INS_WALK: begin
        cmd.rd    = 1'b1;
        cmd.shift = 1'b1;
        cmd.up    = 1'b1;
        if (stat.ptr_first) begin
          state_next = S_INS_DRAIN;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_INS_DRAIN: begin
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = S_DONE;
      end
      // move later entries down one slot
      S_DEL_WALK: begin
        if (stat.ptr_end) begin
          state_next = S_DEL_FIN;
        end else begin
          cmd.rd      = 1'b1;
          cmd.shift   = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      S_DEL_FIN: begin
        cmd.cnt_dec = 1'b1;
        cmd.set_ok  = 1'b1;
        state_next  = S_DONE;
      end
      S_GET_FIN: begin
        cmd.set_ok = 1'b1;
        state_next = S_DONE;
      end
      // compare falls in the cycle after the read
      S_LOC_WALK: begin
        if (stat.hit || stat.ptr_end) begin
          state_next = S_DONE;
        end else begin
          cmd.rd      = 1'b1;
          cmd.cmp     = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE) && req_valid)
    else $error("item loaded outside idle");

  a_no_busy_write: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_val |=> state == S_DONE)
    else $error("value write not followed by result");

  a_out_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE)
    else $error("result handed over but still busy");

endmodule

`default_nettype wire

// ----- rtl/positional_array_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of up to CAPACITY signed 32-bit entries with insert, delete,
// get, locate and clear commands, one result item per command item.
// ----------------------------------------------------------------------------
// One command item is taken at a time. Entries live in a single-port-read,
// single-port-write RAM, and insert, delete and locate walk it one entry per
// cycle, so the item time follows the walk length: insert walks from the tail
// down to position p (no walk when appending), delete from p up to the tail,
// locate from the first entry until a hit or the end; get, clear and a
// rejected command do not walk. A result that meets a stalled output
// register waits until it frees. A new item can be accepted while the
// previous result is still held in the output register.
// Positions above 127 cannot be addressed; length and found position are
// reported modulo 128. The entry RAM needs no clearing after reset.
`default_nettype none

module positional_array_list_core #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire pal_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output pal_pkg::rsp_t      rsp
);

  pal_pkg::dp_cmd_t  cmd;
  pal_pkg::dp_stat_t stat;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
